// ===== sv/hmi_pkg.sv =====
// Shared constants for the joint-histogram mutual information block.
package hmi_pkg;

    localparam int BINS_DEF        = 50;
    localparam int COUNT_BITS_DEF  = 24;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int              MAXV_BITS  = 16;
    localparam logic [15:0]     MAXV_RESET = 16'hFFFF;

    localparam int              FRAC_BITS  = 28;     // log2 fraction bits
    localparam int              RATIO_BITS = 32;     // c/N quotient bits
    localparam logic [23:0]     LN2_Q24    = 24'd11629080;
    localparam int              ACC_BITS   = 64;

    localparam int MI_BITS = 32;
    localparam int SC_BITS = 24;

endpackage

// ===== sv/hmi_ifs.sv =====
// Valid/ready channel interfaces for pixel pairs and results.
interface hmi_in_if #(
    parameter int SAMPLE_BITS = hmi_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] x_sample;
    logic [SAMPLE_BITS-1:0] y_sample;
    logic                   last;

    modport source (output valid, x_sample, y_sample, last, input ready);
    modport sink   (input valid, x_sample, y_sample, last, output ready);
endinterface

interface hmi_out_if;
    logic                          valid;
    logic                          ready;
    logic [hmi_pkg::MI_BITS-1:0]   mutual_info;
    logic [hmi_pkg::SC_BITS-1:0]   sample_count;
    logic                          overflow;

    modport source (output valid, mutual_info, sample_count, overflow, input ready);
    modport sink   (input valid, mutual_info, sample_count, overflow, output ready);
endinterface

// ===== sv/hmi_quant.sv =====
// Sample to bin quantizer: restoring division, one quotient bit per cycle.
module hmi_quant #(
    parameter int BINS        = hmi_pkg::BINS_DEF,
    parameter int SAMPLE_BITS = hmi_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [SAMPLE_BITS-1:0]      sample,
    input  logic [hmi_pkg::MAXV_BITS-1:0] top,
    output logic                        busy,
    output logic [$clog2(BINS)-1:0]     bin
);

    localparam int QB = $clog2(BINS);
    localparam int NW = SAMPLE_BITS + QB + 18;
    localparam int CW = $clog2(QB + 1);

    logic [NW-1:0] num_reg, num_next;
    logic [NW-1:0] den_reg;
    logic [QB-1:0] q_reg;
    logic [CW-1:0] cnt_reg;
    logic          sat_reg;
    logic          busy_reg;
    logic          ge;

    assign ge       = num_reg >= den_reg;
    assign num_next = ge ? num_reg - den_reg : num_reg;
    assign busy     = busy_reg;
    assign bin      = sat_reg ? QB'(BINS - 1) : q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            num_reg  <= '0;
            den_reg  <= '0;
            q_reg    <= '0;
            cnt_reg  <= '0;
            sat_reg  <= 1'b0;
        end
        else if (start)
        begin
            // numerator 2*v*(BINS-1)+top, divisor 2*top aligned to the top quotient bit
            num_reg  <= NW'(sample) * NW'(2 * (BINS - 1)) + NW'(top);
            den_reg  <= NW'(top) << QB;
            q_reg    <= '0;
            cnt_reg  <= CW'(QB);
            sat_reg  <= {{(hmi_pkg::MAXV_BITS + 1){1'b0}}, sample} >= {{(SAMPLE_BITS + 1){1'b0}}, top};
            busy_reg <= 1'b1;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            den_reg <= den_reg >> 1;
            q_reg   <= QB'({q_reg, ge});
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== sv/hmi_log2.sv =====
// Iterative log2 unit: leading-one search, then 28 squaring steps, Q.28 result.
module hmi_log2 #(
    parameter int COUNT_BITS = hmi_pkg::COUNT_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [COUNT_BITS-1:0]     arg,
    output logic                      busy,
    output logic [$clog2(COUNT_BITS)+hmi_pkg::FRAC_BITS-1:0] result
);

    localparam int EW = $clog2(COUNT_BITS);
    localparam int FB = hmi_pkg::FRAC_BITS;
    localparam int LW = EW + FB;
    localparam int CW = $clog2(FB);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_NORM = 2'd1;
    localparam logic [1:0] PH_SQ   = 2'd2;

    logic [1:0]              phase_reg;
    logic [COUNT_BITS-1:0]   w_reg;
    logic [EW-1:0]           e_reg;
    logic [30:0]             m_reg;
    logic [FB-1:0]           frac_reg;
    logic [CW-1:0]           cnt_reg;
    logic [LW-1:0]           res_reg;

    logic [COUNT_BITS+30:0]  wide;
    logic [30:0]             m_init;
    logic [61:0]             sq;
    logic [31:0]             mn;
    logic                    fbit;
    logic [30:0]             m_nxt;

    assign wide   = {w_reg, 31'b0};
    assign m_init = wide[COUNT_BITS+30:COUNT_BITS];
    assign sq     = 62'(m_reg) * 62'(m_reg);
    assign mn     = sq[61:30];
    assign fbit   = mn[31];
    assign m_nxt  = fbit ? mn[31:1] : mn[30:0];
    assign busy   = phase_reg != PH_IDLE;
    assign result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            w_reg     <= '0;
            e_reg     <= '0;
            m_reg     <= '0;
            frac_reg  <= '0;
            cnt_reg   <= '0;
            res_reg   <= '0;
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (start)
                    begin
                        if (arg == '0)
                        begin
                            res_reg <= '0;
                        end
                        else
                        begin
                            w_reg     <= arg;
                            e_reg     <= EW'(COUNT_BITS - 1);
                            phase_reg <= PH_NORM;
                        end
                    end
                end
                PH_NORM:
                begin
                    if (w_reg[COUNT_BITS-1])
                    begin
                        m_reg     <= m_init;
                        frac_reg  <= '0;
                        cnt_reg   <= '0;
                        phase_reg <= PH_SQ;
                    end
                    else
                    begin
                        w_reg <= w_reg << 1;
                        e_reg <= e_reg - 1'b1;
                    end
                end
                PH_SQ:
                begin
                    m_reg    <= m_nxt;
                    frac_reg <= {frac_reg[FB-2:0], fbit};
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(FB - 1))
                    begin
                        res_reg   <= {e_reg, frac_reg[FB-2:0], fbit};
                        phase_reg <= PH_IDLE;
                    end
                end
                default:
                begin
                    phase_reg <= PH_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/hmi_ratio.sv =====
// Restoring divider for c*2^32/N with c <= N, one quotient bit per cycle.
module hmi_ratio #(
    parameter int COUNT_BITS = hmi_pkg::COUNT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [COUNT_BITS-1:0]              num,
    input  logic [COUNT_BITS-1:0]              den,
    output logic                               busy,
    output logic [hmi_pkg::RATIO_BITS:0]       ratio
);

    localparam int RB = hmi_pkg::RATIO_BITS;
    localparam int CW = $clog2(RB);

    logic [COUNT_BITS-1:0] r_reg;
    logic [COUNT_BITS-1:0] n_reg;
    logic [RB-1:0]         q_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  busy_reg;
    logic [RB:0]           res_reg;

    logic [COUNT_BITS:0]   r2;
    logic [COUNT_BITS:0]   r2_sub;
    logic                  ge;

    assign r2     = {r_reg, 1'b0};
    assign ge     = r2 >= {1'b0, n_reg};
    assign r2_sub = r2 - {1'b0, n_reg};
    assign busy   = busy_reg;
    assign ratio  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            r_reg    <= '0;
            n_reg    <= '0;
            q_reg    <= '0;
            cnt_reg  <= '0;
            res_reg  <= '0;
        end
        else if (start)
        begin
            if (den == '0)
            begin
                res_reg <= '0;
            end
            else if (num >= den)
            begin
                res_reg <= {1'b1, {RB{1'b0}}};
            end
            else
            begin
                r_reg    <= num;
                n_reg    <= den;
                q_reg    <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
        end
        else if (busy_reg)
        begin
            r_reg   <= ge ? r2_sub[COUNT_BITS-1:0] : r2[COUNT_BITS-1:0];
            q_reg   <= {q_reg[RB-2:0], ge};
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(RB - 1))
            begin
                res_reg  <= {1'b0, q_reg[RB-2:0], ge};
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== sv/joint_histogram_mutual_information.sv =====
// Top level: joint/marginal histogram memories, update sequencer and MI walk.
//
// Usage:
//   in_ch carries one pixel pair per transaction (x_sample, y_sample, last).
//   Each pair is quantized, then counted by read-modify-write of the joint
//   memory and of the marginal memory (first image in the low half, second
//   image in the high half). Each pair passes through the bit-serial
//   quantizer and two marginal updates through the single marginal port;
//   in_ch.ready is high only between pairs.
//   The pair flagged last is counted, then the joint memory is walked entry
//   by entry: an empty entry is skipped, a filled one goes through the
//   shared log2 unit (leading-one search plus 28 squarings) and the
//   32-step divider for c/N.
//   One transaction on out_ch then gives mutual_info (Q4.28 nats),
//   sample_count and overflow. It stays in an output register until taken;
//   a stalled receiver only delays the next walk's result.
//   After reset and after every result a clearing pass over all BINS*BINS
//   joint entries zeroes both memories; no pair is taken meanwhile.
//   cfg_wr_en/cfg_wr_data write max_value; write it only while idle.
module joint_histogram_mutual_information #(
    parameter int BINS        = hmi_pkg::BINS_DEF,
    parameter int COUNT_BITS  = hmi_pkg::COUNT_BITS_DEF,
    parameter int SAMPLE_BITS = hmi_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [hmi_pkg::MAXV_BITS-1:0]  cfg_wr_data,
    hmi_in_if.sink                         in_ch,
    hmi_out_if.source                      out_ch
);

    localparam int BW   = $clog2(BINS);
    localparam int JD   = BINS * BINS;
    localparam int JAW  = $clog2(JD);
    localparam int MD   = 2 * BINS;
    localparam int MAW  = $clog2(MD);
    localparam int LW   = $clog2(COUNT_BITS) + hmi_pkg::FRAC_BITS;
    localparam int DW   = LW + 2;
    localparam int LNW  = LW + 1;
    localparam int PW   = hmi_pkg::RATIO_BITS + 1;
    localparam int HIW  = PW + LNW - 16;
    localparam int LOW  = PW + 16;
    localparam int AW   = hmi_pkg::ACC_BITS;
    localparam int MIW  = hmi_pkg::MI_BITS;

    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_QUANT = 5'd2;
    localparam logic [4:0] S_UPD1  = 5'd3;
    localparam logic [4:0] S_UPD2  = 5'd4;
    localparam logic [4:0] S_WINIT = 5'd5;
    localparam logic [4:0] S_WLGN  = 5'd6;
    localparam logic [4:0] S_WRD   = 5'd7;
    localparam logic [4:0] S_WCHK  = 5'd8;
    localparam logic [4:0] S_WLC   = 5'd9;
    localparam logic [4:0] S_WMX   = 5'd10;
    localparam logic [4:0] S_WLX   = 5'd11;
    localparam logic [4:0] S_WMY   = 5'd12;
    localparam logic [4:0] S_WLY   = 5'd13;
    localparam logic [4:0] S_WDIV  = 5'd14;
    localparam logic [4:0] S_WMUL  = 5'd15;
    localparam logic [4:0] S_WACC  = 5'd16;
    localparam logic [4:0] S_WOUT  = 5'd17;

    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    // memories
    logic [COUNT_BITS-1:0] joint_mem [JD];
    logic [COUNT_BITS-1:0] marg_mem  [MD];

    logic [4:0]              state_reg, state_next;
    logic [JAW-1:0]          clr_reg;
    logic [hmi_pkg::MAXV_BITS-1:0] max_value_reg;
    logic                    last_reg;
    logic [COUNT_BITS-1:0]   pair_total_reg;
    logic                    sat_reg;
    logic [JAW-1:0]          jidx_reg;
    logic [BW-1:0]           ix_reg, iy_reg;
    logic [COUNT_BITS-1:0]   c_reg;
    logic [LW-1:0]           lgn_reg;
    logic signed [DW-1:0]    d_reg;
    logic [LNW-1:0]          lnm_reg;
    logic [HIW-1:0]          hi_reg;
    logic [LOW-1:0]          lo_reg;
    logic signed [AW-1:0]    acc_reg;
    logic [COUNT_BITS-1:0]   jrd_reg, mrd_reg;

    logic                    out_valid_reg;
    logic [MIW-1:0]          mi_reg;
    logic [hmi_pkg::SC_BITS-1:0] sc_reg;
    logic                    ovf_reg;

    // memory port controls
    logic                    j_we, m_we;
    logic [JAW-1:0]          j_wa, j_ra;
    logic [MAW-1:0]          m_wa, m_ra;
    logic [COUNT_BITS-1:0]   j_wd, m_wd;

    // unit handshakes
    logic                    in_acc;
    logic [hmi_pkg::MAXV_BITS-1:0] top_val;
    logic                    qx_busy, qy_busy;
    logic [BW-1:0]           q_bx, q_by;
    logic                    lg_start, lg_busy;
    logic [COUNT_BITS-1:0]   lg_arg;
    logic [LW-1:0]           lg_res;
    logic                    rt_start, rt_busy;
    logic [PW-1:0]           rt_res;

    logic [JAW-1:0]          jaddr;
    logic                    j_full, m_full, n_full;
    logic                    last_entry;
    logic                    mag_neg;
    logic [LNW-1:0]          mag;
    logic [LNW+23:0]         ln_prod;
    logic [HIW:0]            t_sum;
    logic [HIW-16:0]         term;
    logic [MIW-1:0]          mi_clamp;

    assign in_acc  = in_ch.valid && in_ch.ready;
    assign top_val = (max_value_reg == '0) ? hmi_pkg::MAXV_BITS'(1) : max_value_reg;
    assign jaddr   = JAW'(q_bx) * JAW'(BINS) + JAW'(q_by);

    assign j_full  = jrd_reg == CMAX;
    assign m_full  = mrd_reg == CMAX;
    assign n_full  = pair_total_reg == CMAX;
    assign last_entry = jidx_reg == JAW'(JD - 1);

    // ln(x) = ln2 * log2(x), on the magnitude
    assign mag_neg = d_reg[DW-1];
    assign mag     = mag_neg ? LNW'(-d_reg) : LNW'(d_reg);
    assign ln_prod = (LNW + 24)'(mag) * (LNW + 24)'(hmi_pkg::LN2_Q24);

    assign t_sum = (HIW + 1)'(hi_reg) + (HIW + 1)'(lo_reg >> 16);
    assign term  = t_sum[HIW:16];

    assign mi_clamp = acc_reg[AW-1] ? '0 :
                      (|acc_reg[AW-2:MIW]) ? {MIW{1'b1}} : acc_reg[MIW-1:0];

    assign in_ch.ready         = state_reg == S_IDLE;
    assign out_ch.valid        = out_valid_reg;
    assign out_ch.mutual_info  = mi_reg;
    assign out_ch.sample_count = sc_reg;
    assign out_ch.overflow     = ovf_reg;

    hmi_quant #(.BINS(BINS), .SAMPLE_BITS(SAMPLE_BITS)) u_quant_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_acc),
        .sample (in_ch.x_sample),
        .top    (top_val),
        .busy   (qx_busy),
        .bin    (q_bx)
    );

    hmi_quant #(.BINS(BINS), .SAMPLE_BITS(SAMPLE_BITS)) u_quant_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_acc),
        .sample (in_ch.y_sample),
        .top    (top_val),
        .busy   (qy_busy),
        .bin    (q_by)
    );

    hmi_log2 #(.COUNT_BITS(COUNT_BITS)) u_log2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (lg_start),
        .arg    (lg_arg),
        .busy   (lg_busy),
        .result (lg_res)
    );

    hmi_ratio #(.COUNT_BITS(COUNT_BITS)) u_ratio (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (rt_start),
        .num    (c_reg),
        .den    (pair_total_reg),
        .busy   (rt_busy),
        .ratio  (rt_res)
    );

    // synchronous memories, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (j_we)
        begin
            joint_mem[j_wa] <= j_wd;
        end
        jrd_reg <= joint_mem[j_ra];
    end

    always_ff @(posedge clk)
    begin
        if (m_we)
        begin
            marg_mem[m_wa] <= m_wd;
        end
        mrd_reg <= marg_mem[m_ra];
    end

    // sequencer and memory port steering
    always_comb
    begin
        state_next = state_reg;
        j_we     = 1'b0;
        j_wa     = jaddr;
        j_wd     = j_full ? jrd_reg : jrd_reg + 1'b1;
        j_ra     = jidx_reg;
        m_we     = 1'b0;
        m_wa     = MAW'(q_bx);
        m_wd     = m_full ? mrd_reg : mrd_reg + 1'b1;
        m_ra     = MAW'(ix_reg);
        lg_start = 1'b0;
        lg_arg   = mrd_reg;
        rt_start = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                j_we = 1'b1;
                j_wa = clr_reg;
                j_wd = '0;
                m_we = 32'(clr_reg) < MD;
                m_wa = MAW'(clr_reg);
                m_wd = '0;
                if (clr_reg == JAW'(JD - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_QUANT;
                end
            end
            S_QUANT:
            begin
                j_ra = jaddr;
                m_ra = MAW'(q_bx);
                if (!qx_busy && !qy_busy)
                begin
                    state_next = S_UPD1;
                end
            end
            S_UPD1:
            begin
                // write joint and first marginal, fetch second marginal
                j_we = 1'b1;
                m_we = 1'b1;
                m_ra = MAW'(BINS) + MAW'(q_by);
                state_next = S_UPD2;
            end
            S_UPD2:
            begin
                m_we = 1'b1;
                m_wa = MAW'(BINS) + MAW'(q_by);
                state_next = last_reg ? S_WINIT : S_IDLE;
            end
            S_WINIT:
            begin
                lg_start   = 1'b1;
                lg_arg     = pair_total_reg;
                state_next = S_WLGN;
            end
            S_WLGN:
            begin
                if (!lg_busy)
                begin
                    state_next = S_WRD;
                end
            end
            S_WRD:
            begin
                state_next = S_WCHK;
            end
            S_WCHK:
            begin
                if (jrd_reg == '0)
                begin
                    state_next = last_entry ? S_WOUT : S_WRD;
                end
                else
                begin
                    lg_start   = 1'b1;
                    lg_arg     = jrd_reg;
                    state_next = S_WLC;
                end
            end
            S_WLC:
            begin
                m_ra = MAW'(ix_reg);
                if (!lg_busy)
                begin
                    state_next = S_WMX;
                end
            end
            S_WMX:
            begin
                lg_start   = 1'b1;
                state_next = S_WLX;
            end
            S_WLX:
            begin
                m_ra = MAW'(BINS) + MAW'(iy_reg);
                if (!lg_busy)
                begin
                    state_next = S_WMY;
                end
            end
            S_WMY:
            begin
                lg_start   = 1'b1;
                state_next = S_WLY;
            end
            S_WLY:
            begin
                if (!lg_busy)
                begin
                    rt_start   = 1'b1;
                    state_next = S_WDIV;
                end
            end
            S_WDIV:
            begin
                if (!rt_busy)
                begin
                    state_next = S_WMUL;
                end
            end
            S_WMUL:
            begin
                state_next = S_WACC;
            end
            S_WACC:
            begin
                state_next = last_entry ? S_WOUT : S_WRD;
            end
            S_WOUT:
            begin
                if (!out_valid_reg)
                begin
                    state_next = S_CLEAR;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            max_value_reg  <= hmi_pkg::MAXV_RESET;
            last_reg       <= 1'b0;
            pair_total_reg <= '0;
            sat_reg        <= 1'b0;
            jidx_reg       <= '0;
            ix_reg         <= '0;
            iy_reg         <= '0;
            c_reg          <= '0;
            lgn_reg        <= '0;
            d_reg          <= '0;
            lnm_reg        <= '0;
            hi_reg         <= '0;
            lo_reg         <= '0;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
            mi_reg         <= '0;
            sc_reg         <= '0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                max_value_reg <= cfg_wr_data;
            end

            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= (clr_reg == JAW'(JD - 1)) ? '0 : clr_reg + 1'b1;
                end
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        last_reg <= in_ch.last;
                    end
                end
                S_UPD1:
                begin
                    if (!n_full)
                    begin
                        pair_total_reg <= pair_total_reg + 1'b1;
                    end
                    if (n_full || j_full || m_full)
                    begin
                        sat_reg <= 1'b1;
                    end
                end
                S_UPD2:
                begin
                    if (m_full)
                    begin
                        sat_reg <= 1'b1;
                    end
                end
                S_WINIT:
                begin
                    acc_reg  <= '0;
                    jidx_reg <= '0;
                    ix_reg   <= '0;
                    iy_reg   <= '0;
                end
                S_WLGN:
                begin
                    lgn_reg <= lg_res;
                end
                S_WCHK:
                begin
                    c_reg <= jrd_reg;
                    if (jrd_reg == '0)
                    begin
                        jidx_reg <= jidx_reg + 1'b1;
                        if (iy_reg == BW'(BINS - 1))
                        begin
                            iy_reg <= '0;
                            ix_reg <= ix_reg + 1'b1;
                        end
                        else
                        begin
                            iy_reg <= iy_reg + 1'b1;
                        end
                    end
                end
                S_WLC:
                begin
                    d_reg <= $signed(DW'(lg_res)) + $signed(DW'(lgn_reg));
                end
                S_WLX, S_WLY:
                begin
                    // take the marginal log once, when the unit is done
                    if (!lg_busy)
                    begin
                        d_reg <= d_reg - $signed(DW'(lg_res));
                    end
                end
                S_WDIV:
                begin
                    lnm_reg <= ln_prod[LNW+23:24];
                end
                S_WMUL:
                begin
                    hi_reg <= HIW'(rt_res) * HIW'(lnm_reg[LNW-1:16]);
                    lo_reg <= LOW'(rt_res) * LOW'(lnm_reg[15:0]);
                end
                S_WACC:
                begin
                    if (mag_neg)
                    begin
                        acc_reg <= acc_reg - $signed(AW'(term));
                    end
                    else
                    begin
                        acc_reg <= acc_reg + $signed(AW'(term));
                    end
                    jidx_reg <= jidx_reg + 1'b1;
                    if (iy_reg == BW'(BINS - 1))
                    begin
                        iy_reg <= '0;
                        ix_reg <= ix_reg + 1'b1;
                    end
                    else
                    begin
                        iy_reg <= iy_reg + 1'b1;
                    end
                end
                S_WOUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg  <= 1'b1;
                        mi_reg         <= mi_clamp;
                        sc_reg         <= hmi_pkg::SC_BITS'(pair_total_reg);
                        ovf_reg        <= sat_reg;
                        pair_total_reg <= '0;
                        sat_reg        <= 1'b0;
                        clr_reg        <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule
